FILE: hw/rtl/dcf_pkg.sv
// dcf_pkg: shared constants and types of the decimal ascii formatter
// used by dcf_dabble, dcf_out_reg, decimal_ascii_formatter and the testbench; no dependencies
package dcf_pkg;

	// width of the signed input value
	localparam int VALUE_BITS = 32;
	// decimal digits of the largest magnitude, 2**(VALUE_BITS-1); 1233/4096 ~ log10(2)
	localparam int DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
	localparam int DIG_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	// iteration counter must hold VALUE_BITS itself
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	// stream data widths, padded to whole bytes
	localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
	localparam int CHAR_W = 7;
	localparam int OUT_TDATA_W = 8;

	// ascii codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

	// bcd digit vector, digit 0 is the least significant
	typedef logic [DIGITS-1:0][3:0] bcd_t;

	// one output character transaction
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic last;
	} char_t;

	// control from the sequencer to the conversion unit
	typedef struct packed {
		logic start;
		logic [VALUE_BITS-1:0] mag;
	} dab_ctl_t;

	// status from the conversion unit back to the sequencer
	typedef struct packed {
		logic busy;
		bcd_t bcd;
	} dab_stat_t;

endpackage

FILE: hw/rtl/dcf_dabble.sv
// dcf_dabble: binary to bcd conversion, one shift-add-3 step per cycle
// depends on dcf_pkg
module dcf_dabble (
	input  logic clk,
	input  logic arst_n,
	input  dcf_pkg::dab_ctl_t ctl,
	output dcf_pkg::dab_stat_t stat
);

	localparam int BCD_W = dcf_pkg::DIGITS * 4;
	localparam int CAT_W = BCD_W + dcf_pkg::VALUE_BITS;

	logic [dcf_pkg::CNT_W-1:0] cnt_q;
	logic [dcf_pkg::VALUE_BITS-1:0] bin_q;
	dcf_pkg::bcd_t bcd_q;
	dcf_pkg::bcd_t bcd_adj;
	logic [CAT_W-1:0] cat;
	logic [CAT_W-1:0] cat_sh;

	// add 3 to every digit of 5 or more, then shift the whole word left
	always_comb begin
		for (int i = 0; i < dcf_pkg::DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		cat = {bcd_adj, bin_q};
		cat_sh = {cat[CAT_W-2:0], 1'b0};
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= dcf_pkg::CNT_W'(dcf_pkg::VALUE_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - dcf_pkg::CNT_W'(1);
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			bin_q <= ctl.mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= cat_sh[dcf_pkg::VALUE_BITS-1:0];
			bcd_q <= cat_sh[CAT_W-1 -: BCD_W];
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.bcd = bcd_q;

endmodule

FILE: hw/rtl/dcf_out_reg.sv
// dcf_out_reg: output holding register of the character stream
// depends on dcf_pkg
module dcf_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  dcf_pkg::char_t in_char,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output dcf_pkg::char_t out_char
);

	logic valid_q;
	dcf_pkg::char_t char_q;

	assign in_ready = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_q <= in_char;
		end
	end

	assign out_valid = valid_q;
	assign out_char = char_q;

endmodule

FILE: hw/rtl/decimal_ascii_formatter.sv
// decimal_ascii_formatter: signed integer in, decimal ascii characters out
// depends on dcf_pkg, dcf_dabble, dcf_out_reg
//
// channel   dir  signals                                  meaning
// s_axis    in   tvalid tready tdata[IN_TDATA_W]          one signed value per transaction
// m_axis    out  tvalid tready tdata[8] tlast             one character per transaction
//
// a value is taken only when the block is idle; it is loaded, runs VALUE_BITS (32)
// shift-add-3 steps in the bcd unit, settles, skips each leading zero digit (up to
// DIGITS-1) and leaves the scan, then sends one character per cycle while m_axis does
// not stall (1 to 11 characters at 32 bits)
// most of the time per value goes to the single bit-per-cycle bcd shifter
// a stalled m_axis holds the sequencer on the current character; nothing is lost
// arst_n clears the sequencer, the shifter counter and the output valid flag
module decimal_ascii_formatter (
	input  logic clk,
	input  logic arst_n,
	// value = tdata[VALUE_BITS-1:0], upper bits ignored
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [dcf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// char_code = tdata[6:0], tdata[7] = 0
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [dcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_SKIP  = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	localparam int VB = dcf_pkg::VALUE_BITS;
	localparam int IW = dcf_pkg::DIG_IDX_W;

	logic [2:0] state_q;
	logic neg_q;
	logic [IW-1:0] dig_idx_q;
	logic in_acc;
	logic [VB-1:0] value;
	dcf_pkg::dab_ctl_t dab_ctl;
	dcf_pkg::dab_stat_t dab_stat;
	logic [3:0] cur_digit;
	logic ch_valid;
	logic ch_ready;
	dcf_pkg::char_t ch;
	dcf_pkg::char_t out_ch;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign value = s_axis_tdata[VB-1:0];

	// unsigned magnitude, exact for the most negative value
	assign dab_ctl.start = in_acc;
	assign dab_ctl.mag = value[VB-1] ? (~value + VB'(1)) : value;

	dcf_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dab_ctl),
		.stat   (dab_stat)
	);

	assign cur_digit = dab_stat.bcd[dig_idx_q];

	// character offered to the output register
	always_comb begin
		ch_valid = 1'b0;
		ch.code = dcf_pkg::CHAR_MINUS;
		ch.last = 1'b0;
		case (state_q)
			ST_SIGN: begin
				ch_valid = 1'b1;
			end
			ST_DIGIT: begin
				ch_valid = 1'b1;
				ch.code = dcf_pkg::CHAR_ZERO + dcf_pkg::CHAR_W'(cur_digit);
				ch.last = (dig_idx_q == '0);
			end
			default: begin
				ch_valid = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q <= 1'b0;
			dig_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q <= value[VB-1];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (!dab_stat.busy) begin
						dig_idx_q <= IW'(dcf_pkg::DIGITS - 1);
						state_q <= ST_SKIP;
					end
				end
				// walk down past leading zero digits
				ST_SKIP: begin
					if (cur_digit == 4'd0 && dig_idx_q != '0) begin
						dig_idx_q <= dig_idx_q - IW'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (ch_ready) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (ch_ready) begin
						if (dig_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							dig_idx_q <= dig_idx_q - IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	dcf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ch_valid),
		.in_char   (ch),
		.in_ready  (ch_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_ch)
	);

	assign m_axis_tdata = {1'b0, out_ch.code};
	assign m_axis_tlast = out_ch.last;

	// a new value is never taken while the shifter still runs
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !dab_stat.busy)
		else $error("input accepted while conversion unit busy");

	// an accepted value starts the shifter on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> dab_stat.busy)
		else $error("conversion did not start after accept");

	// only valid bcd digits are sent
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGIT |-> cur_digit <= 4'd9)
		else $error("non-decimal digit reached output");

	// the last character ends the run and frees the input
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT && ch_ready && dig_idx_q == '0) |=> s_axis_tready)
		else $error("block not idle after last character");

endmodule

FILE: verif/testbench.sv
// testbench: self-checking regression of decimal_ascii_formatter
// drives signed values on s_axis, predicts the decimal text and checks every m_axis character
// depends on dcf_pkg and the decimal_ascii_formatter rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [dcf_pkg::VALUE_BITS-1:0] value_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	localparam int LIMIT_CYCLES = 400_000;
	localparam int RANDOM_ITEMS = 308;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AFTER = 400;
	localparam int MAX_REPORTS = 60;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [dcf_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [dcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// pending values and whether the sender drains the block before each one
	value_t pending_values[$];
	bit pending_drain[$];
	// characters predicted but not yet seen
	dcf_pkg::char_t expected_chars[$];
	int chars_expected = 0;
	int chars_seen = 0;
	int error_count = 0;

	decimal_ascii_formatter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// decimal text of one value: optional minus, digits msd first, last flag on the final one
	function automatic void format_decimal(value_t v);
		logic [dcf_pkg::VALUE_BITS-1:0] mag;
		logic [3:0] digit_q[$];
		dcf_pkg::char_t c;
		mag = v[dcf_pkg::VALUE_BITS-1] ? (~v + 1'b1) : v;
		do begin
			digit_q.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (v[dcf_pkg::VALUE_BITS-1]) begin
			c.code = dcf_pkg::CHAR_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
			chars_expected++;
		end
		foreach (digit_q[i]) begin
			c.code = dcf_pkg::CHAR_ZERO + dcf_pkg::CHAR_W'(digit_q[i]);
			c.last = (i == digit_q.size() - 1);
			expected_chars.push_back(c);
			chars_expected++;
		end
	endfunction

	// random value: any bit pattern, or a chosen digit count with edge or uniform magnitude
	function automatic value_t random_value();
		longint unsigned span_lo, span_hi, mag, mag_cap;
		int n_digits;
		int pick;
		bit neg;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return value_t'({$urandom, $urandom});
		neg = 1'($urandom_range(0, 1));
		n_digits = $urandom_range(1, dcf_pkg::DIGITS);
		span_hi = 1;
		repeat (n_digits) span_hi = span_hi * 10;
		span_lo = (n_digits == 1) ? 0 : span_hi / 10;
		span_hi = span_hi - 1;
		mag_cap = (64'd1 << (dcf_pkg::VALUE_BITS - 1)) - (neg ? 0 : 1);
		if (span_hi > mag_cap)
			span_hi = mag_cap;
		if (pick < 4)
			mag = $urandom_range(0, 1) ? span_lo : span_hi;
		else
			mag = span_lo + ({$urandom, $urandom} % (span_hi - span_lo + 1));
		return neg ? value_t'(~mag + 1) : value_t'(mag);
	endfunction

	// sender: bursts of random length with random gaps, optional drain before an item
	int gap_left = 0;
	int burst_left = 0;
	bit offer;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			offer = s_axis_tvalid;
			// accepted transaction: predict its characters
			if (s_axis_tvalid && s_axis_tready) begin
				format_decimal(pending_values.pop_front());
				void'(pending_drain.pop_front());
				offer = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
				end
			end
			if (!offer) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_values.size() != 0 &&
						!(pending_drain[0] && chars_seen != chars_expected))
					offer = 1'b1;
			end
			s_axis_tvalid <= offer;
			if (offer)
				s_axis_tdata <= dcf_pkg::IN_TDATA_W'(pending_values[0]);
		end
	end

	// receiver ready pattern with one long hold-off
	rx_mode_t rx_mode = RX_OPEN;
	int rx_mode_left = 0;
	int rx_hold_left = 0;
	int rx_chars = 0;
	int rx_cycle = 0;
	bit long_hold_done = 1'b0;
	bit ready_next;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				ready_next = 1'b0;
			end else if (!long_hold_done && rx_chars >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rx_hold_left = LONG_HOLD_CYCLES;
				ready_next = 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(16, 96);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					RX_OPEN: ready_next = 1'b1;
					RX_COIN: ready_next = 1'($urandom_range(0, 1));
					RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = rx_cycle[2];
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				rx_chars++;
			rx_cycle++;
			m_axis_tready <= ready_next;
		end
	end

	// character check against the oldest prediction
	always @(posedge clk) begin : char_check
		dcf_pkg::char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_seen <= chars_seen + 1;
			if (expected_chars.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected character, expected none, actual 0x%02h tlast %0b",
						$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata !== dcf_pkg::OUT_TDATA_W'(want.code)) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: char_code mismatch, expected 0x%02h actual 0x%02h",
							$time, dcf_pkg::OUT_TDATA_W'(want.code), m_axis_tdata);
				end
				if (m_axis_tlast !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: tlast mismatch, expected %0b actual %0b",
							$time, want.last, m_axis_tlast);
				end
			end
		end
	end

	// run limit
	initial begin : run_limit
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("decimal_ascii_formatter regression: fail");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin : stimulus
		value_t min_value;
		value_t max_value;
		value_t directed[$];
		min_value = {1'b1, {(dcf_pkg::VALUE_BITS - 1){1'b0}}};
		max_value = ~min_value;
		// extremes, zero, digit-count boundaries, alternating bit patterns
		directed = '{value_t'(0), value_t'(1), value_t'(-1), value_t'(9), value_t'(-9),
			value_t'(10), value_t'(-10), value_t'(99), value_t'(100), value_t'(-100),
			max_value, min_value, min_value + 1, max_value - 1,
			value_t'(999999999), value_t'(1000000000), value_t'(-999999999),
			value_t'(-1000000000), value_t'(123456789), value_t'(-123456789),
			value_t'(32'h5555_5555), value_t'(32'hAAAA_AAAA), value_t'(7)};
		foreach (directed[i]) begin
			pending_values.push_back(directed[i]);
			pending_drain.push_back(i == 12);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pending_values.push_back(random_value());
			pending_drain.push_back(i == 150 || $urandom_range(0, 49) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_values.size() != 0)
			@(posedge clk);
		while (chars_seen < chars_expected)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			error_count++;
			$display("%0t: %0d characters expected but never seen", $time, expected_chars.size());
		end
		if (error_count == 0)
			$display("decimal_ascii_formatter regression: pass");
		else
			$display("decimal_ascii_formatter regression: fail");
		$finish;
	end

endmodule

FILE: decimal_ascii_formatter.f
hw/rtl/dcf_pkg.sv
hw/rtl/dcf_dabble.sv
hw/rtl/dcf_out_reg.sv
hw/rtl/decimal_ascii_formatter.sv
verif/testbench.sv
